[hw/rtl/point_projection_mask_marker_unit_assert.svh]
// assertion macros for the point projection mask marker checker
// expects clk and rst_n in the scope of each use
`ifndef POINT_PROJECTION_MASK_MARKER_UNIT_ASSERT_SVH
`define POINT_PROJECTION_MASK_MARKER_UNIT_ASSERT_SVH

// same-cycle implication
`define PPM_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error("ppm port check failed");

// next-cycle implication
`define PPM_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("ppm port check failed");

`endif

[hw/rtl/ppm_pkg.sv]
// shared types, constants and transform coefficients of the mask marker
// no dependencies
`timescale 1ns / 1ps

package ppm_pkg;

    // default store geometry
    localparam int MAX_MASK_COLS_DEF = 1024;
    localparam int MAX_MASK_ROWS_DEF = 1024;

    // config register reset values
    localparam logic [10:0] MASK_WIDTH_RST  = 11'd640;
    localparam logic [10:0] MASK_HEIGHT_RST = 11'd480;

    // datapath widths: transformed coordinate, divider numerator and divisor
    localparam int TW     = 34;
    localparam int DIV_NW = 50;
    localparam int DIV_DW = 34;

    // ratio saturation, Q16.16
    localparam logic [30:0] RATIO_LIMIT = 31'h4000_0000;

    // request kinds
    localparam logic REQ_MASK_WRITE = 1'b0;
    localparam logic REQ_POINT      = 1'b1;

    // config register indexes
    typedef enum logic [2:0] {
        CFG_FOCAL_X     = 3'd0,
        CFG_FOCAL_Y     = 3'd1,
        CFG_CENTER_X    = 3'd2,
        CFG_CENTER_Y    = 3'd3,
        CFG_MASK_WIDTH  = 3'd4,
        CFG_MASK_HEIGHT = 3'd5
    } ppm_cfg_idx_t;

    // rotation, signed Q2.30, row-major
    localparam logic signed [31:0] ROT [3][3] = '{
        '{ 32'sd1073720352,   32'sd6467225,   -32'sd2069855},
        '{  -32'sd6415693, 32'sd1073413310,   32'sd25772277},
        '{   32'sd2224451,   -32'sd25759394, 32'sd1073430487}
    };

    // translation, signed Q.46
    localparam logic signed [63:0] TRANS [3] = '{
        64'sd70368744178, 64'sd985162418487, -64'sd492581209244
    };

    // one word as classified by the front
    typedef struct packed {
        logic               is_point;
        logic               wr_en;
        logic               wr_bit;
        logic [19:0]        pix_idx;
        logic [7:0]         blue;
        logic [7:0]         green;
        logic [7:0]         red;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } ppm_item_t;

    // word plus projection flags riding along the back pipeline
    typedef struct packed {
        ppm_item_t item;
        logic      neg_x;
        logic      neg_y;
        logic      zero_z;
    } ppm_tag_t;

    // camera registers
    typedef struct packed {
        logic [31:0] focal_x;
        logic [31:0] focal_y;
        logic [31:0] center_x;
        logic [31:0] center_y;
    } ppm_cam_t;

endpackage

[hw/rtl/ppm_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module ppm_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[hw/rtl/ppm_front.sv]
// front: accepts input words, classifies them and tracks mask frame completion
// depends on ppm_pkg
`timescale 1ns / 1ps

module ppm_front
    import ppm_pkg::*;
#(
    parameter int MASK_DEPTH = MAX_MASK_COLS_DEF * MAX_MASK_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [19:0]        pixel_index,
    input  logic               frame_done,
    input  logic [7:0]         blue_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         red_in,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    input  logic               q_full,
    output logic               q_push,
    output ppm_item_t          q_item
);

    logic mask_ready_reg;
    logic mask_ready_next;
    logic accept;

    assign in_stall = q_full;
    assign accept   = in_valid && !in_stall;

    // mask becomes usable once a frame has been closed
    always_comb
    begin
        mask_ready_next = mask_ready_reg;
        if (accept && (req_type == REQ_MASK_WRITE) && frame_done)
        begin
            mask_ready_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_ready_reg <= 1'b0;
        end
        else
        begin
            mask_ready_reg <= mask_ready_next;
        end
    end

    // classify: pure red pixel, write inside the store, points dropped before first frame
    always_comb
    begin
        q_item.is_point = (req_type == REQ_POINT);
        q_item.wr_en    = ({12'd0, pixel_index} < 32'(MASK_DEPTH));
        q_item.wr_bit   = (red_in == 8'hFF) && (green_in == 8'h00) && (blue_in == 8'h00);
        q_item.pix_idx  = pixel_index;
        q_item.blue     = blue_in;
        q_item.green    = green_in;
        q_item.red      = red_in;
        q_item.x        = coord_x;
        q_item.y        = coord_y;
        q_item.z        = coord_z;
    end

    assign q_push = accept && ((req_type == REQ_MASK_WRITE) || mask_ready_reg);

endmodule

[hw/rtl/ppm_fifo.sv]
// short queue between front and back
// depends on ppm_pkg
`timescale 1ns / 1ps

module ppm_fifo
    import ppm_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  ppm_item_t push_item,
    input  logic      pop,
    output ppm_item_t head_item,
    output logic      empty,
    output logic      full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    ppm_item_t        slot [DEPTH];
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    rd_ptr_next;
    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;

    assign empty     = (count_reg == '0);
    assign full      = (count_reg == CW'(DEPTH));
    assign head_item = slot[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[hw/rtl/ppm_div.sv]
// pipelined restoring divider, two numerators over a shared divisor, one quotient bit per stage
// depends on ppm_pkg
`timescale 1ns / 1ps

module ppm_div
    import ppm_pkg::*;
(
    input  logic              clk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num_a,
    input  logic [DIV_NW-1:0] num_b,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_NW-1:0] quo_a,
    output logic [DIV_NW-1:0] quo_b
);

    localparam int NW = DIV_NW;
    localparam int DW = DIV_DW;

    logic [DW-1:0] rem_a_reg [NW];
    logic [DW-1:0] rem_b_reg [NW];
    logic [NW-1:0] quo_a_reg [NW];
    logic [NW-1:0] quo_b_reg [NW];
    logic [NW-1:0] num_a_reg [NW];
    logic [NW-1:0] num_b_reg [NW];
    logic [DW-1:0] den_reg   [NW];

    logic [DW-1:0] src_rem_a [NW];
    logic [DW-1:0] src_rem_b [NW];
    logic [NW-1:0] src_quo_a [NW];
    logic [NW-1:0] src_quo_b [NW];
    logic [NW-1:0] src_num_a [NW];
    logic [NW-1:0] src_num_b [NW];
    logic [DW-1:0] src_den   [NW];

    logic [DW:0]   step_a    [NW];
    logic [DW:0]   step_b    [NW];

    // one restoring step: msb is the quotient bit, rest the new remainder
    function automatic logic [DW:0] div_step(input logic [DW-1:0] rem,
                                             input logic nb,
                                             input logic [DW-1:0] d);
        logic [DW:0] r2;
        r2 = {rem, nb};
        if (r2 >= {1'b0, d})
        begin
            return {1'b1, DW'(r2 - {1'b0, d})};
        end
        return {1'b0, r2[DW-1:0]};
    endfunction

    // stage inputs: first stage from the ports, others from the previous stage
    always_comb
    begin
        src_rem_a[0] = '0;
        src_rem_b[0] = '0;
        src_quo_a[0] = '0;
        src_quo_b[0] = '0;
        src_num_a[0] = num_a;
        src_num_b[0] = num_b;
        src_den[0]   = den;
        for (int k = 1; k < NW; k++)
        begin
            src_rem_a[k] = rem_a_reg[k-1];
            src_rem_b[k] = rem_b_reg[k-1];
            src_quo_a[k] = quo_a_reg[k-1];
            src_quo_b[k] = quo_b_reg[k-1];
            src_num_a[k] = num_a_reg[k-1];
            src_num_b[k] = num_b_reg[k-1];
            src_den[k]   = den_reg[k-1];
        end
        for (int k = 0; k < NW; k++)
        begin
            step_a[k] = div_step(src_rem_a[k], src_num_a[k][NW-1], src_den[k]);
            step_b[k] = div_step(src_rem_b[k], src_num_b[k][NW-1], src_den[k]);
        end
    end

    // stage registers
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < NW; k++)
            begin
                rem_a_reg[k] <= step_a[k][DW-1:0];
                rem_b_reg[k] <= step_b[k][DW-1:0];
                quo_a_reg[k] <= {src_quo_a[k][NW-2:0], step_a[k][DW]};
                quo_b_reg[k] <= {src_quo_b[k][NW-2:0], step_b[k][DW]};
                num_a_reg[k] <= {src_num_a[k][NW-2:0], 1'b0};
                num_b_reg[k] <= {src_num_b[k][NW-2:0], 1'b0};
                den_reg[k]   <= src_den[k];
            end
        end
    end

    assign quo_a = quo_a_reg[NW-1];
    assign quo_b = quo_b_reg[NW-1];

endmodule

[hw/rtl/ppm_back.sv]
// back: transform, projection, mask memory access and output register
// depends on ppm_pkg, ppm_div, ppm_ram
`timescale 1ns / 1ps

module ppm_back
    import ppm_pkg::*;
#(
    parameter int MAX_MASK_COLS = MAX_MASK_COLS_DEF,
    parameter int MAX_MASK_ROWS = MAX_MASK_ROWS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  ppm_item_t                           head_item,
    input  logic                                q_empty,
    output logic                                q_pop,
    input  ppm_cam_t                            cam,
    input  logic [$clog2(MAX_MASK_COLS+1)-1:0]  w_eff,
    input  logic [$clog2(MAX_MASK_ROWS+1)-1:0]  h_eff,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic signed [31:0]                  out_x,
    output logic signed [31:0]                  out_y,
    output logic signed [31:0]                  out_z,
    output logic [7:0]                          out_red,
    output logic [7:0]                          out_green,
    output logic [7:0]                          out_blue,
    output logic                                marked
);

    localparam int WCW   = $clog2(MAX_MASK_COLS + 1);
    localparam int HCW   = $clog2(MAX_MASK_ROWS + 1);
    localparam int CW    = $clog2(MAX_MASK_COLS);
    localparam int RW    = $clog2(MAX_MASK_ROWS);
    localparam int DEPTH = MAX_MASK_COLS * MAX_MASK_ROWS;
    localparam int AW    = $clog2(DEPTH);
    localparam int NW    = DIV_NW;

    logic adv;

    // stage 1: products
    logic                v1_reg;
    ppm_item_t           it1_reg;
    logic signed [63:0]  prod_reg [3][3];
    logic signed [31:0]  pv [3];

    // stage 2: partial sums
    logic                v2_reg;
    ppm_item_t           it2_reg;
    logic signed [63:0]  s01_reg [3];
    logic signed [63:0]  s2t_reg [3];

    // stage 3: transformed coordinates
    logic                v3_reg;
    ppm_item_t           it3_reg;
    logic signed [TW-1:0] t_reg [3];
    logic [64:0]         sum65 [3];

    // stage 4: divider operands
    logic                v4_reg;
    ppm_tag_t            tag4_reg;
    logic [DIV_NW-1:0]   num_x_reg;
    logic [DIV_NW-1:0]   num_y_reg;
    logic [DIV_DW-1:0]   den_reg;
    logic [TW-1:0]       mag [3];

    // divider side line
    logic                vd_reg   [NW];
    ppm_tag_t            tagd_reg [NW];
    logic [DIV_NW-1:0]   quo_x;
    logic [DIV_NW-1:0]   quo_y;

    // stage 5: saturated ratio
    logic                v5_reg;
    ppm_tag_t            tag5_reg;
    logic [30:0]         rx_reg;
    logic [30:0]         ry_reg;

    // stage 6: ratio times focal
    logic                v6_reg;
    ppm_tag_t            tag6_reg;
    logic [62:0]         mx_reg;
    logic [62:0]         my_reg;

    // stage 7: pixel column and row
    logic                v7_reg;
    ppm_tag_t            tag7_reg;
    logic [CW-1:0]       col_reg;
    logic [RW-1:0]       row_reg;
    logic                inx_reg;
    logic                iny_reg;
    logic [65:0]         sx;
    logic [65:0]         sy;
    logic [33:0]         px;
    logic [33:0]         py;
    logic                in_x;
    logic                in_y;

    // stage 8: mask address
    logic                v8_reg;
    ppm_item_t           it8_reg;
    logic [AW-1:0]       addr_reg;
    logic                ok8_reg;

    // output register
    logic                out_valid_reg;
    logic signed [31:0]  out_x_reg;
    logic signed [31:0]  out_y_reg;
    logic signed [31:0]  out_z_reg;
    logic [7:0]          out_red_reg;
    logic [7:0]          out_green_reg;
    logic [7:0]          out_blue_reg;
    logic                out_ok_reg;
    logic                mask_bit;
    logic                hit;
    logic                ram_we;
    logic                ram_re;

    // whole back advances unless a finished result is held
    assign adv   = !out_valid_reg || !out_stall;
    assign q_pop = adv && !q_empty;

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            v5_reg        <= 1'b0;
            v6_reg        <= 1'b0;
            v7_reg        <= 1'b0;
            v8_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int k = 0; k < NW; k++)
            begin
                vd_reg[k] <= 1'b0;
            end
        end
        else if (adv)
        begin
            v1_reg    <= q_pop;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            vd_reg[0] <= v4_reg;
            for (int k = 1; k < NW; k++)
            begin
                vd_reg[k] <= vd_reg[k-1];
            end
            v5_reg        <= vd_reg[NW-1];
            v6_reg        <= v5_reg;
            v7_reg        <= v6_reg;
            v8_reg        <= v7_reg;
            out_valid_reg <= v8_reg && it8_reg.is_point;
        end
    end

    // transform front end
    always_comb
    begin
        pv[0] = head_item.x;
        pv[1] = head_item.y;
        pv[2] = head_item.z;
        for (int i = 0; i < 3; i++)
        begin
            sum65[i] = {s01_reg[i][63], s01_reg[i]} + {s2t_reg[i][63], s2t_reg[i]};
            mag[i]   = t_reg[i][TW-1] ? TW'(-t_reg[i]) : TW'(t_reg[i]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            it1_reg <= head_item;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    prod_reg[i][j] <= ROT[i][j] * pv[j];
                end
            end
            it2_reg <= it1_reg;
            for (int i = 0; i < 3; i++)
            begin
                s01_reg[i] <= prod_reg[i][0] + prod_reg[i][1];
                s2t_reg[i] <= prod_reg[i][2] + TRANS[i];
            end
            // floor to Q16.16 is an arithmetic shift
            it3_reg <= it2_reg;
            for (int i = 0; i < 3; i++)
            begin
                t_reg[i] <= sum65[i][63:30];
            end
            tag4_reg.item   <= it3_reg;
            tag4_reg.neg_x  <= t_reg[0][TW-1] ^ t_reg[2][TW-1];
            tag4_reg.neg_y  <= t_reg[1][TW-1] ^ t_reg[2][TW-1];
            tag4_reg.zero_z <= (t_reg[2] == '0);
            num_x_reg       <= DIV_NW'({mag[0], 16'd0});
            num_y_reg       <= DIV_NW'({mag[1], 16'd0});
            den_reg         <= DIV_DW'(mag[2]);
        end
    end

    // magnitude division, truncation toward zero
    ppm_div u_div (
        .clk   (clk),
        .en    (adv),
        .num_a (num_x_reg),
        .num_b (num_y_reg),
        .den   (den_reg),
        .quo_a (quo_x),
        .quo_b (quo_y)
    );

    // projection arithmetic for column and row
    always_comb
    begin
        sx = tag6_reg.neg_x ? (66'd0 - {3'd0, mx_reg}) : {3'd0, mx_reg};
        sx = sx + {18'd0, cam.center_x, 16'd0};
        sy = tag6_reg.neg_y ? (66'd0 - {3'd0, my_reg}) : {3'd0, my_reg};
        sy = sy + {18'd0, cam.center_y, 16'd0};
        px = sx[65] ? 34'd0 : sx[65:32];
        py = sy[65] ? 34'd0 : sy[65:32];
        // negative sums within one pixel of zero still land on pixel zero
        in_x = !(sx[65] && !((&sx[65:32]) && (|sx[31:0]))) && (px < 34'(w_eff));
        in_y = !(sy[65] && !((&sy[65:32]) && (|sy[31:0]))) && (py < 34'(h_eff));
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            tagd_reg[0] <= tag4_reg;
            for (int k = 1; k < NW; k++)
            begin
                tagd_reg[k] <= tagd_reg[k-1];
            end
            // ratio saturation
            tag5_reg <= tagd_reg[NW-1];
            rx_reg   <= (quo_x > DIV_NW'(RATIO_LIMIT)) ? RATIO_LIMIT : quo_x[30:0];
            ry_reg   <= (quo_y > DIV_NW'(RATIO_LIMIT)) ? RATIO_LIMIT : quo_y[30:0];
            tag6_reg <= tag5_reg;
            mx_reg   <= 63'(rx_reg) * 63'(cam.focal_x);
            my_reg   <= 63'(ry_reg) * 63'(cam.focal_y);
            tag7_reg <= tag6_reg;
            col_reg  <= px[CW-1:0];
            row_reg  <= py[RW-1:0];
            inx_reg  <= in_x;
            iny_reg  <= in_y;
            // row-major address
            it8_reg  <= tag7_reg.item;
            addr_reg <= AW'(AW'(row_reg) * AW'(w_eff) + AW'(col_reg));
            ok8_reg  <= inx_reg && iny_reg && !tag7_reg.zero_z;
        end
    end

    // mask store access in stream order
    assign ram_we = adv && v8_reg && !it8_reg.is_point && it8_reg.wr_en;
    assign ram_re = adv && v8_reg && it8_reg.is_point;

    ppm_ram #(
        .WIDTH (1),
        .DEPTH (DEPTH)
    ) u_mask_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (AW'(it8_reg.pix_idx)),
        .wdata (it8_reg.wr_bit),
        .re    (ram_re),
        .raddr (addr_reg),
        .rdata (mask_bit)
    );

    // output word
    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            out_x_reg     <= it8_reg.x;
            out_y_reg     <= it8_reg.y;
            out_z_reg     <= it8_reg.z;
            out_red_reg   <= it8_reg.red;
            out_green_reg <= it8_reg.green;
            out_blue_reg  <= it8_reg.blue;
            out_ok_reg    <= ok8_reg;
        end
    end

    assign hit       = out_ok_reg && mask_bit;
    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign out_z     = out_z_reg;
    assign out_red   = hit ? 8'h00 : out_red_reg;
    assign out_green = hit ? 8'hFF : out_green_reg;
    assign out_blue  = hit ? 8'h00 : out_blue_reg;
    assign marked    = hit;

endmodule

[hw/rtl/point_projection_mask_marker_unit.sv]
// point projection mask marker, top level: config registers, front, queue, back
// depends on ppm_pkg, ppm_front, ppm_fifo, ppm_back
// path from input accept to result word: queue, 4 transform stages,
// 50 divider stages, 4 projection stages, output register
// throughput: one word per cycle while out_stall is low; the divider retires one quotient bit per stage
// reset clears mask_ready and loads config defaults; mask bits are undefined until written
`timescale 1ns / 1ps

module point_projection_mask_marker_unit
    import ppm_pkg::*;
#(
    parameter int MAX_MASK_COLS = MAX_MASK_COLS_DEF,
    parameter int MAX_MASK_ROWS = MAX_MASK_ROWS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               req_type,
    input  logic [19:0]        pixel_index,
    input  logic               frame_done,
    input  logic [7:0]         blue_in,
    input  logic [7:0]         green_in,
    input  logic [7:0]         red_in,
    input  logic signed [31:0] coord_x,
    input  logic signed [31:0] coord_y,
    input  logic signed [31:0] coord_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic signed [31:0] out_x,
    output logic signed [31:0] out_y,
    output logic signed [31:0] out_z,
    output logic [7:0]         out_red,
    output logic [7:0]         out_green,
    output logic [7:0]         out_blue,
    output logic               marked,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int WCW = $clog2(MAX_MASK_COLS + 1);
    localparam int HCW = $clog2(MAX_MASK_ROWS + 1);

    ppm_cam_t    cam_reg;
    logic [10:0] mask_width_reg;
    logic [10:0] mask_height_reg;
    logic [WCW-1:0] w_eff;
    logic [HCW-1:0] h_eff;

    logic      q_push;
    logic      q_pop;
    logic      q_full;
    logic      q_empty;
    ppm_item_t q_in;
    ppm_item_t q_head;

    assign cfg_ready = 1'b1;

    // config register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg         <= '0;
            mask_width_reg  <= MASK_WIDTH_RST;
            mask_height_reg <= MASK_HEIGHT_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (ppm_cfg_idx_t'(cfg_index))
                CFG_FOCAL_X:     cam_reg.focal_x  <= cfg_data;
                CFG_FOCAL_Y:     cam_reg.focal_y  <= cfg_data;
                CFG_CENTER_X:    cam_reg.center_x <= cfg_data;
                CFG_CENTER_Y:    cam_reg.center_y <= cfg_data;
                CFG_MASK_WIDTH:  mask_width_reg   <= cfg_data[10:0];
                CFG_MASK_HEIGHT: mask_height_reg  <= cfg_data[10:0];
                default:         ;
            endcase
        end
    end

    // mask size clipped to the store
    assign w_eff = (32'(mask_width_reg) < 32'(MAX_MASK_COLS)) ? WCW'(mask_width_reg)
                                                              : WCW'(MAX_MASK_COLS);
    assign h_eff = (32'(mask_height_reg) < 32'(MAX_MASK_ROWS)) ? HCW'(mask_height_reg)
                                                               : HCW'(MAX_MASK_ROWS);

    ppm_front #(
        .MASK_DEPTH (MAX_MASK_COLS * MAX_MASK_ROWS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .req_type    (req_type),
        .pixel_index (pixel_index),
        .frame_done  (frame_done),
        .blue_in     (blue_in),
        .green_in    (green_in),
        .red_in      (red_in),
        .coord_x     (coord_x),
        .coord_y     (coord_y),
        .coord_z     (coord_z),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_item      (q_in)
    );

    ppm_fifo #(
        .DEPTH (4)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_in),
        .pop       (q_pop),
        .head_item (q_head),
        .empty     (q_empty),
        .full      (q_full)
    );

    ppm_back #(
        .MAX_MASK_COLS (MAX_MASK_COLS),
        .MAX_MASK_ROWS (MAX_MASK_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head_item (q_head),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .cam       (cam_reg),
        .w_eff     (w_eff),
        .h_eff     (h_eff),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_x     (out_x),
        .out_y     (out_y),
        .out_z     (out_z),
        .out_red   (out_red),
        .out_green (out_green),
        .out_blue  (out_blue),
        .marked    (marked)
    );

endmodule

[hw/rtl/ppm_checker.sv]
// port-level checker for the mask marker, bound to the top level
// depends on point_projection_mask_marker_unit_assert.svh
`timescale 1ns / 1ps
`include "point_projection_mask_marker_unit_assert.svh"

module ppm_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               req_type,
    input logic [19:0]        pixel_index,
    input logic               frame_done,
    input logic [7:0]         blue_in,
    input logic [7:0]         green_in,
    input logic [7:0]         red_in,
    input logic signed [31:0] coord_x,
    input logic signed [31:0] coord_y,
    input logic signed [31:0] coord_z,
    input logic               out_valid,
    input logic               out_stall,
    input logic signed [31:0] out_x,
    input logic signed [31:0] out_y,
    input logic signed [31:0] out_z,
    input logic [7:0]         out_red,
    input logic [7:0]         out_green,
    input logic [7:0]         out_blue,
    input logic               marked,
    input logic               cfg_valid,
    input logic               cfg_ready,
    input logic [2:0]         cfg_index,
    input logic [31:0]        cfg_data
);

    // a stalled result word holds
    `PPM_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_x) && $stable(out_y) && $stable(out_z) && $stable(marked))

    // a marked point always leaves green
    `PPM_ASSERT_NOW(a_marked_green, out_valid && marked, (out_red == 8'h00) && (out_green == 8'hFF) && (out_blue == 8'h00))

    // no result right after reset release
    `PPM_ASSERT_NOW(a_quiet_after_reset, $rose(rst_n), !out_valid)

    // config writes are never held off
    `PPM_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready)

endmodule

bind point_projection_mask_marker_unit ppm_checker u_ppm_checker (.*);
